// File: sv/bprf_pkg.sv
package bprf_pkg;

  localparam int unsigned TS_W  = 32;
  localparam int unsigned CFG_W = 32;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned CODE_W = 3;

  typedef enum logic [CODE_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_PRESSED  = 3'd2,
    PH_REPEAT   = 3'd3,
    PH_RELEASE  = 3'd4
  } phase_t;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE    = 3'd0,
    EV_PRESSED = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_RELEASE = 3'd4
  } event_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic            pin_level;
    logic [TS_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] event_code;
    logic [CODE_W-1:0] fsm_state;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] repeat_interval;
  } cfg_times_t;

endpackage

// File: sv/bprf_cfg_regs.sv
module bprf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [bprf_pkg::IDX_W-1:0]    wr_index,
  input  logic [bprf_pkg::CFG_W-1:0]    wr_data,
  output bprf_pkg::cfg_times_t          times
);

  bprf_pkg::cfg_times_t times_r;
  bprf_pkg::cfg_times_t times_nxt;

  always_comb begin
    times_nxt = times_r;
    if (wr_en) begin
      case (wr_index)
        bprf_pkg::REG_DEBOUNCE: times_nxt.debounce_time   = wr_data;
        bprf_pkg::REG_LONG:     times_nxt.long_press_time = wr_data;
        bprf_pkg::REG_REPEAT:   times_nxt.repeat_interval = wr_data;
        default:                times_nxt = times_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      times_r.debounce_time   <= bprf_pkg::CFG_W'(50);
      times_r.long_press_time <= bprf_pkg::CFG_W'(1000);
      times_r.repeat_interval <= bprf_pkg::CFG_W'(200);
    end else begin
      times_r <= times_nxt;
    end
  end

  assign times = times_r;

endmodule

// File: sv/bprf_fsm.sv
module bprf_fsm #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  bprf_pkg::in_item_t    item,
  input  bprf_pkg::cfg_times_t  times,
  output bprf_pkg::out_item_t   res
);

  localparam int unsigned WIDE_W = 64;

  bprf_pkg::phase_t        phase_r;
  bprf_pkg::phase_t        phase_nxt;
  logic [TIME_WIDTH-1:0]   mark_r;
  logic [TIME_WIDTH-1:0]   mark_nxt;
  bprf_pkg::event_t        ev;

  logic [WIDE_W-1:0]       now_wide;
  logic [WIDE_W-1:0]       deb_wide;
  logic [WIDE_W-1:0]       long_wide;
  logic [WIDE_W-1:0]       rep_wide;
  logic [TIME_WIDTH-1:0]   now_cut;
  logic [TIME_WIDTH-1:0]   elapsed;
  logic                    pressed;
  logic                    past_deb;
  logic                    past_long;
  logic                    past_rep;

  assign now_wide  = {{(WIDE_W-bprf_pkg::TS_W){1'b0}}, item.now_ms};
  assign deb_wide  = {{(WIDE_W-bprf_pkg::CFG_W){1'b0}}, times.debounce_time};
  assign long_wide = {{(WIDE_W-bprf_pkg::CFG_W){1'b0}}, times.long_press_time};
  assign rep_wide  = {{(WIDE_W-bprf_pkg::CFG_W){1'b0}}, times.repeat_interval};
  assign now_cut   = now_wide[TIME_WIDTH-1:0];
  assign elapsed   = now_cut - mark_r;
  assign pressed   = !item.pin_level;
  assign past_deb  = elapsed > deb_wide[TIME_WIDTH-1:0];
  assign past_long = elapsed > long_wide[TIME_WIDTH-1:0];
  assign past_rep  = elapsed > rep_wide[TIME_WIDTH-1:0];

  always_comb begin
    phase_nxt = phase_r;
    mark_nxt  = mark_r;
    ev        = bprf_pkg::EV_NONE;
    case (phase_r)
      bprf_pkg::PH_DEBOUNCE: begin
        if (past_deb) begin
          if (pressed) begin
            phase_nxt = bprf_pkg::PH_PRESSED;
            mark_nxt  = now_cut;
            ev        = bprf_pkg::EV_PRESSED;
          end else begin
            phase_nxt = bprf_pkg::PH_IDLE;
          end
        end
      end
      bprf_pkg::PH_PRESSED: begin
        if (!pressed) begin
          phase_nxt = bprf_pkg::PH_RELEASE;
        end else if (past_long) begin
          phase_nxt = bprf_pkg::PH_REPEAT;
          mark_nxt  = now_cut;
          ev        = bprf_pkg::EV_LONG;
        end
      end
      bprf_pkg::PH_REPEAT: begin
        if (!pressed) begin
          phase_nxt = bprf_pkg::PH_RELEASE;
        end else if (past_rep) begin
          mark_nxt = now_cut;
          ev       = bprf_pkg::EV_REPEAT;
        end
      end
      bprf_pkg::PH_RELEASE: begin
        phase_nxt = bprf_pkg::PH_IDLE;
        ev        = bprf_pkg::EV_RELEASE;
      end
      default: begin
        phase_nxt = bprf_pkg::PH_IDLE;
        if (pressed) begin
          phase_nxt = bprf_pkg::PH_DEBOUNCE;
          mark_nxt  = now_cut;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bprf_pkg::PH_IDLE;
      mark_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mark_r  <= mark_nxt;
    end
  end

  assign res.event_code = ev;
  assign res.fsm_state  = phase_nxt;

`ifndef SYNTH
  a_release_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == bprf_pkg::PH_RELEASE |=> phase_r == bprf_pkg::PH_IDLE)
    else $error("release did not return to idle");

  a_repeat_only_held: assert property (@(posedge clk) disable iff (!rst_n)
    ev == bprf_pkg::EV_REPEAT |-> phase_r == bprf_pkg::PH_REPEAT && pressed)
    else $error("repeat event outside repeat mode");

  a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(mark_r) && $stable(phase_r))
    else $error("state moved without a request");
`endif

endmodule

// File: sv/button_press_repeat_fsm_unit.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   bprf_pkg::in_item_t  (pin_level, now_ms)
// out_     output     out_valid / out_stall bprf_pkg::out_item_t (event_code, fsm_state)
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// Each request yields exactly one result via the input and result registers.
// One request per cycle is taken while in_stall is low.
// Reset (synchronous, rst_n low) sets state idle, mark time zero and the
// configured times to 50, 1000 and 200; cfg_ready is always high.
// in_stall rises only when the input register is full and the result
// register is held by out_stall.
module button_press_repeat_fsm_unit #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bprf_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bprf_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bprf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bprf_pkg::CFG_W-1:0]  cfg_wdata
);

  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  bprf_pkg::in_item_t    s1_data_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  bprf_pkg::out_item_t   out_data_r;
  logic                  out_free;
  logic                  advance;
  bprf_pkg::cfg_times_t  times;
  bprf_pkg::out_item_t   fsm_res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;

  bprf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .times    (times)
  );

  bprf_fsm #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_data_r),
    .times (times),
    .res   (fsm_res)
  );

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= fsm_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && out_data_r == $past(fsm_res))
    else $error("result register missed a request");

  a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_code == bprf_pkg::EV_RELEASE
      |-> out_data_r.fsm_state == bprf_pkg::PH_IDLE)
    else $error("release event not paired with idle");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic [bprf_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic PIN_DOWN = 1'b0;
  localparam logic PIN_UP = 1'b1;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bprf_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bprf_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bprf_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bprf_pkg::CFG_W-1:0] cfg_wdata = '0;

  button_press_repeat_fsm_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  bprf_pkg::in_item_t poll_queue[$];
  bprf_pkg::out_item_t pending_reports[$];
  bprf_pkg::out_item_t want_report;

  bprf_pkg::phase_t cur_phase = bprf_pkg::PH_IDLE;
  logic [bprf_pkg::TS_W-1:0] mark_ms = '0;
  bprf_pkg::cfg_times_t times = '{debounce_time: 32'd50, long_press_time: 32'd1000,
                                  repeat_interval: 32'd200};

  bit poll_taken = 1'b0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int fail_count = 0;
  int cycle_count = 0;
  logic [bprf_pkg::TS_W-1:0] stamp_ms = '0;

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bprf_pkg::out_item_t predict_poll(bprf_pkg::in_item_t poll);
    logic held;
    logic [bprf_pkg::TS_W-1:0] elapsed;
    bprf_pkg::event_t ev;
    held = !poll.pin_level;
    elapsed = poll.now_ms - mark_ms;
    ev = bprf_pkg::EV_NONE;
    case (cur_phase)
      bprf_pkg::PH_DEBOUNCE: begin
        if (elapsed > times.debounce_time) begin
          if (held) begin
            cur_phase = bprf_pkg::PH_PRESSED;
            mark_ms = poll.now_ms;
            ev = bprf_pkg::EV_PRESSED;
          end else begin
            cur_phase = bprf_pkg::PH_IDLE;
          end
        end
      end
      bprf_pkg::PH_PRESSED: begin
        if (!held) begin
          cur_phase = bprf_pkg::PH_RELEASE;
        end else if (elapsed > times.long_press_time) begin
          cur_phase = bprf_pkg::PH_REPEAT;
          mark_ms = poll.now_ms;
          ev = bprf_pkg::EV_LONG;
        end
      end
      bprf_pkg::PH_REPEAT: begin
        if (!held) begin
          cur_phase = bprf_pkg::PH_RELEASE;
        end else if (elapsed > times.repeat_interval) begin
          mark_ms = poll.now_ms;
          ev = bprf_pkg::EV_REPEAT;
        end
      end
      bprf_pkg::PH_RELEASE: begin
        ev = bprf_pkg::EV_RELEASE;
        cur_phase = bprf_pkg::PH_IDLE;
      end
      default: begin
        cur_phase = bprf_pkg::PH_IDLE;
        if (held) begin
          cur_phase = bprf_pkg::PH_DEBOUNCE;
          mark_ms = poll.now_ms;
        end
      end
    endcase
    return bprf_pkg::out_item_t'{event_code: ev, fsm_state: cur_phase};
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !poll_taken) begin
      // hold the stalled request
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (poll_queue.size() > 0) begin
      in_data <= poll_queue.pop_front();
      in_valid <= 1'b1;
      send_gap = send_steady ? 0 : idle_span();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    poll_taken = rst_n && in_valid && !in_stall;
    if (poll_taken) pending_reports.push_back(predict_poll(in_data));
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        bprf_pkg::REG_DEBOUNCE: times.debounce_time = cfg_wdata;
        bprf_pkg::REG_LONG: times.long_press_time = cfg_wdata;
        bprf_pkg::REG_REPEAT: times.repeat_interval = cfg_wdata;
        default: ;
      endcase
    end
  end

  // result monitor
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!recv_steady && $urandom_range(0, 3) == 0) stall_left = idle_span();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: event_code %0d fsm_state %0d",
               out_data.event_code, out_data.fsm_state);
        fail_count++;
      end else begin
        want_report = pending_reports.pop_front();
        if (out_data.event_code !== want_report.event_code) begin
          $error("event_code expected %0d got %0d", want_report.event_code,
                 out_data.event_code);
          fail_count++;
        end
        if (out_data.fsm_state !== want_report.fsm_state) begin
          $error("fsm_state expected %0d got %0d", want_report.fsm_state,
                 out_data.fsm_state);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("button_press_repeat_fsm_unit verification failed");
      $finish;
    end
  end

  task automatic add_poll(logic pin, logic [bprf_pkg::TS_W-1:0] ms);
    bprf_pkg::in_item_t poll;
    poll.pin_level = pin;
    poll.now_ms = ms;
    poll_queue.push_back(poll);
  endtask

  // idle, hold with occasional bounce, release
  task automatic add_press(int hold, int max_step);
    for (int k = 0; k < hold + 4; k++) begin
      stamp_ms += $urandom_range(0, max_step);
      if (k < 2 || k >= hold + 2) add_poll(PIN_UP, stamp_ms);
      else add_poll(($urandom_range(0, 19) == 0) ? PIN_UP : PIN_DOWN, stamp_ms);
    end
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (poll_queue.size() != 0 || pending_reports.size() != 0 || in_valid);
    repeat (3) @(negedge clk);
  endtask

  task automatic cfg_write(logic [bprf_pkg::IDX_W-1:0] idx,
                           logic [bprf_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic run_phase(logic [bprf_pkg::CFG_W-1:0] deb, logic [bprf_pkg::CFG_W-1:0] lng,
                           logic [bprf_pkg::CFG_W-1:0] rpt, int n_polls, int max_step,
                           int max_hold);
    int added;
    wait_drain();
    cfg_write(bprf_pkg::REG_DEBOUNCE, deb);
    cfg_write(bprf_pkg::REG_LONG, lng);
    cfg_write(bprf_pkg::REG_REPEAT, rpt);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_steady = ($urandom_range(0, 3) == 0);
    recv_steady = ($urandom_range(0, 3) == 0);
    stamp_ms = $urandom();
    added = 0;
    while (added < n_polls) begin
      if ($urandom_range(0, 6) == 0) begin
        add_poll(1'($urandom_range(0, 1)), $urandom());
        added++;
      end else begin
        int hold;
        hold = $urandom_range(1, max_hold);
        add_press(hold, max_step);
        added += hold + 4;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_poll(PIN_UP, 32'd0);
    add_poll(PIN_DOWN, 32'd100);
    add_poll(PIN_DOWN, 32'd150);
    add_poll(PIN_DOWN, 32'd151);
    add_poll(PIN_DOWN, 32'd1151);
    add_poll(PIN_DOWN, 32'd1152);
    add_poll(PIN_DOWN, 32'd1352);
    add_poll(PIN_DOWN, 32'd1353);
    add_poll(PIN_UP, 32'd1400);
    add_poll(PIN_UP, 32'd1401);
    add_poll(PIN_DOWN, 32'd2000);
    add_poll(PIN_UP, 32'd2010);
    add_poll(PIN_UP, 32'd2100);
    add_poll(PIN_DOWN, 32'hFFFF_FFF0);
    add_poll(PIN_DOWN, 32'h0000_0030);
    add_poll(PIN_UP, 32'hFFFF_FFFF);
    add_poll(PIN_DOWN, 32'd5);
    add_poll(PIN_DOWN, 32'hFFFF_FF00);
    add_poll(PIN_DOWN, 32'hFFFF_FF40);
    add_poll(PIN_DOWN, 32'h0000_0329);
    add_poll(PIN_UP, 32'h0000_0400);
    add_poll(PIN_UP, 32'h0000_0401);

    wait_drain();
    cfg_write(REG_UNUSED, $urandom());
    @(negedge clk);
    cfg_valid <= 1'b0;

    run_phase(32'd0, 32'd0, 32'd0, 60, 2, 12);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 40, 1000, 10);
    for (int p = 0; p < 7; p++) begin
      run_phase($urandom_range(0, 20), $urandom_range(0, 120), $urandom_range(0, 40),
                110, $urandom_range(1, 25), ($urandom_range(0, 3) == 0) ? 60 : 30);
    end
    run_phase(32'd50, 32'd1000, 32'd200, 120, 120, 40);

    wait_drain();
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("button_press_repeat_fsm_unit verification clean");
    end else begin
      $display("button_press_repeat_fsm_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/bprf_pkg.sv
sv/bprf_cfg_regs.sv
sv/bprf_fsm.sv
sv/button_press_repeat_fsm_unit.sv
verif/testbench.sv
